>>> src/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg: shared types and constants for the row/column scroll address gen
// Table depths, field widths, command and register codes, port structs.
// ----------------------------------------------------------------------------
package rcs_pkg;

  // Table depths (powers of two)
  localparam int ROW_ENTRIES = 512;
  localparam int COL_ENTRIES = 128;
  localparam int ROW_AW      = $clog2(ROW_ENTRIES);
  localparam int COL_AW      = $clog2(COL_ENTRIES);

  // Coordinate widths
  localparam int X_W = 10;
  localparam int Y_W = 9;

  // Mirror origins for flipped screen
  localparam logic [X_W-1:0] FLIP_X_ORIGIN = X_W'(192);
  localparam logic [Y_W-1:0] FLIP_Y_ORIGIN = Y_W'(256);

  // Layer width masks
  localparam logic [X_W-1:0] MASK_NARROW = X_W'(10'h1ff);
  localparam logic [X_W-1:0] MASK_WIDE   = X_W'(10'h3ff);

  // Pixels per column scroll entry, as a shift
  localparam int COL_SHIFT = 3;

  typedef enum logic [1:0] {
    CMD_ROW_WR = 2'd0,
    CMD_COL_WR = 2'd1,
    CMD_PIXEL  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_SCREEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIDTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT    = 3'd6;

  typedef struct packed {
    cmd_t        command;
    logic [8:0]  table_index;
    logic [15:0] table_data;
    logic [8:0]  screen_row;
    logic [9:0]  screen_col;
  } in_word_t;

  typedef struct packed {
    logic [X_W-1:0] source_x;
    logic [Y_W-1:0] source_y;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        scroll_x_word;
    logic [15:0]        scroll_y_word;
    logic signed [10:0] delta_x;
    logic signed [9:0]  delta_y;
    logic               flip_screen;
    logic               double_width;
    logic [9:0]         clip_left;
  } cfg_t;

  // Clearing pass control
  typedef struct packed {
    logic              active;
    logic [ROW_AW-1:0] addr;
  } clr_t;

  // Stage 1 to stage 2 handoff
  typedef struct packed {
    logic           valid;
    logic           col_wr;
    logic [8:0]     table_index;
    logic [15:0]    table_data;
    logic [X_W-1:0] source_x;
    logic [Y_W-1:0] y_row;
  } s1_t;

endpackage

>>> src/rcs_row_stage.sv
// ----------------------------------------------------------------------------
// rcs_row_stage: row scroll table and input stage
// Writes the row table, reads the row scroll word of a pixel request and
// forms the source x wrapped to the layer width and the y base plus row.
// ----------------------------------------------------------------------------
module rcs_row_stage (
  input  logic             clk,
  input  logic             rst,
  input  rcs_pkg::cfg_t    cfg,
  input  rcs_pkg::clr_t    clr,
  input  logic             accept,
  input  logic             load,
  input  rcs_pkg::in_word_t in_word,
  output rcs_pkg::s1_t     s1
);

  logic [15:0] row_mem [rcs_pkg::ROW_ENTRIES];

  logic                       valid;
  logic                       col_wr;
  logic [8:0]                 table_index;
  logic [15:0]                table_data;
  logic [8:0]                 screen_row;
  logic [9:0]                 screen_col;
  logic [15:0]                rscroll;

  logic [rcs_pkg::ROW_AW+8:0] widx;
  logic [rcs_pkg::ROW_AW+8:0] ridx;
  logic [8:0]                 row_adj;
  logic                       row_wr;
  logic                       pix_rd;

  logic [rcs_pkg::X_W-1:0]    wmask;
  logic [rcs_pkg::X_W-1:0]    x_off;
  logic [rcs_pkg::X_W-1:0]    xb_raw;
  logic [rcs_pkg::X_W-1:0]    xb;
  logic [rcs_pkg::Y_W-1:0]    yb_raw;
  logic [rcs_pkg::Y_W-1:0]    yb;

  assign widx    = (rcs_pkg::ROW_AW + 9)'(in_word.table_index);
  assign row_adj = in_word.screen_row - cfg.delta_y[8:0];
  assign ridx    = (rcs_pkg::ROW_AW + 9)'(row_adj);
  assign row_wr  = accept && (in_word.command == rcs_pkg::CMD_ROW_WR) &&
                   (widx < (rcs_pkg::ROW_AW + 9)'(rcs_pkg::ROW_ENTRIES));
  assign pix_rd  = accept && (in_word.command == rcs_pkg::CMD_PIXEL);

  always_ff @(posedge clk) begin
    if (clr.active) begin
      row_mem[clr.addr] <= '0;
    end else if (row_wr) begin
      row_mem[widx[rcs_pkg::ROW_AW-1:0]] <= in_word.table_data;
    end
    if (pix_rd) begin
      rscroll <= row_mem[ridx[rcs_pkg::ROW_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= accept && ((in_word.command == rcs_pkg::CMD_COL_WR) ||
                          (in_word.command == rcs_pkg::CMD_PIXEL));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_wr      <= (in_word.command == rcs_pkg::CMD_COL_WR);
      table_index <= in_word.table_index;
      table_data  <= in_word.table_data;
      screen_row  <= in_word.screen_row;
      screen_col  <= in_word.screen_col;
    end
  end

  // Source x: clip edge minus global scroll, row scroll and delta, mirrored on flip; y base likewise
  always_comb begin
    wmask  = cfg.double_width ? rcs_pkg::MASK_WIDE : rcs_pkg::MASK_NARROW;
    x_off  = rcs_pkg::X_W'(0) - cfg.scroll_x_word[9:0] - cfg.delta_x[9:0] + cfg.clip_left;
    xb_raw = (x_off - rscroll[9:0]) & wmask;
    xb     = cfg.flip_screen ? ((rcs_pkg::FLIP_X_ORIGIN - xb_raw) & wmask) : xb_raw;
    yb_raw = rcs_pkg::Y_W'(0) - cfg.scroll_y_word[8:0] - cfg.delta_y[8:0];
    yb     = cfg.flip_screen ? (rcs_pkg::FLIP_Y_ORIGIN - yb_raw) : yb_raw;
  end

  always_comb begin
    s1.valid       = valid;
    s1.col_wr      = col_wr;
    s1.table_index = table_index;
    s1.table_data  = table_data;
    s1.source_x    = (xb + screen_col) & wmask;
    s1.y_row       = yb + screen_row;
  end

endmodule

>>> src/rcs_col_stage.sv
// ----------------------------------------------------------------------------
// rcs_col_stage: column scroll table and second stage
// Writes the column table in order with pixel reads, reads the column scroll
// word for the source x and forms the final source y.
// ----------------------------------------------------------------------------
module rcs_col_stage (
  input  logic               clk,
  input  logic               rst,
  input  rcs_pkg::clr_t      clr,
  input  rcs_pkg::s1_t       s1,
  input  logic               advance,
  output logic               s2_valid,
  output rcs_pkg::out_word_t s2_word
);

  logic [15:0] col_mem [rcs_pkg::COL_ENTRIES];

  logic [rcs_pkg::COL_AW+8:0] widx;
  logic [rcs_pkg::COL_AW+6:0] ridx;
  logic [rcs_pkg::ROW_AW:0]   clr_wide;
  logic                       col_wr;
  logic                       pix_rd;
  logic                       clr_wr;

  logic [15:0]                cscroll;
  logic [rcs_pkg::X_W-1:0]    source_x;
  logic [rcs_pkg::Y_W-1:0]    y_row;

  assign widx     = (rcs_pkg::COL_AW + 9)'(s1.table_index);
  assign ridx     = (rcs_pkg::COL_AW + 7)'(s1.source_x[rcs_pkg::X_W-1:rcs_pkg::COL_SHIFT]);
  assign clr_wide = (rcs_pkg::ROW_AW + 1)'(clr.addr);
  assign clr_wr   = clr.active && (clr_wide < (rcs_pkg::ROW_AW + 1)'(rcs_pkg::COL_ENTRIES));
  assign col_wr   = advance && s1.valid && s1.col_wr &&
                    (widx < (rcs_pkg::COL_AW + 9)'(rcs_pkg::COL_ENTRIES));
  assign pix_rd   = advance && s1.valid && !s1.col_wr;

  always_ff @(posedge clk) begin
    if (clr_wr) begin
      col_mem[clr.addr[rcs_pkg::COL_AW-1:0]] <= '0;
    end else if (col_wr) begin
      col_mem[widx[rcs_pkg::COL_AW-1:0]] <= s1.table_data;
    end
    if (pix_rd) begin
      cscroll  <= col_mem[ridx[rcs_pkg::COL_AW-1:0]];
      source_x <= s1.source_x;
      y_row    <= s1.y_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= pix_rd;
    end
  end

  assign s2_word.source_x = source_x;
  assign s2_word.source_y = y_row - cscroll[8:0];

endmodule

>>> src/row_col_scroll_address_gen.sv
// ----------------------------------------------------------------------------
// row_col_scroll_address_gen: tile layer source coordinate generator
// Per-line row scroll and per-8-pixel column scroll turn a screen pixel
// into a layer pixmap coordinate; write commands load the two scroll tables.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload                 | carries
//  ---------+----------------------+-------------------------+------------------------
//  input    | in_valid / in_ready  | in_word (in_word_t)     | table write or pixel
//  result   | out_valid / out_ready| out_word (out_word_t)   | source_x, source_y
//  config   | cfg_we               | cfg_index, cfg_data     | scroll/delta/flip/clip
//
//  One item per cycle sustained while the result side keeps taking and no
//  clearing pass runs; a pixel request reaches out_valid through the row table
//  read at the accepting edge, the column table read and the result register.
//  The two table reads are chained through their registered read ports.
//  Reset starts a clearing pass over both tables; in_ready stays low until
//  it ends, config writes are taken anyway.
//  A stalled result holds; the stages behind it keep filling until full.
//  Write commands and the unused command give no result.
//
module row_col_scroll_address_gen (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rcs_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rcs_pkg::out_word_t                out_word,
  input  logic                              cfg_we,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);

  rcs_pkg::cfg_t      cfg;
  rcs_pkg::clr_t      clr;
  rcs_pkg::s1_t       s1;
  logic               s2_valid;
  rcs_pkg::out_word_t s2_word;

  logic ready3;
  logic ready2;
  logic load1;
  logic accept;

  // Backpressure chain: each stage loads when it is empty or drains
  assign ready3   = !out_valid || out_ready;
  assign ready2   = !s2_valid || ready3;
  assign load1    = !s1.valid || ready2;
  assign in_ready = load1 && !clr.active;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rcs_pkg::REG_SCROLL_X:     cfg.scroll_x_word <= cfg_data;
        rcs_pkg::REG_SCROLL_Y:     cfg.scroll_y_word <= cfg_data;
        rcs_pkg::REG_DELTA_X:      cfg.delta_x       <= cfg_data[10:0];
        rcs_pkg::REG_DELTA_Y:      cfg.delta_y       <= cfg_data[9:0];
        rcs_pkg::REG_FLIP_SCREEN:  cfg.flip_screen   <= cfg_data[0];
        rcs_pkg::REG_DOUBLE_WIDTH: cfg.double_width  <= cfg_data[0];
        rcs_pkg::REG_CLIP_LEFT:    cfg.clip_left     <= cfg_data[9:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Clearing pass: zero one row entry (and, below COL_ENTRIES, its column entry) per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr.active <= 1'b1;
      clr.addr   <= '0;
    end else if (clr.active) begin
      clr.addr <= clr.addr + 1'b1;
      if (clr.addr == rcs_pkg::ROW_AW'(rcs_pkg::ROW_ENTRIES - 1)) begin
        clr.active <= 1'b0;
      end
    end
  end

  rcs_row_stage u_row (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .clr     (clr),
    .accept  (accept),
    .load    (load1),
    .in_word (in_word),
    .s1      (s1)
  );

  rcs_col_stage u_col (
    .clk      (clk),
    .rst      (rst),
    .clr      (clr),
    .s1       (s1),
    .advance  (ready2),
    .s2_valid (s2_valid),
    .s2_word  (s2_word)
  );

  // Result register: hold while stalled, advance when taken or empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready3) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid) begin
      out_word <= s2_word;
    end
  end

  // No item enters while the tables are being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr.active |-> !in_ready)
    else $error("input accepted during clearing pass");

  // Reset restarts the clearing pass from the first entry
  a_clear_restart: assert property (@(posedge clk)
    rst |=> (clr.active && (clr.addr == '0)))
    else $error("clearing pass did not restart after reset");

  // A stage-two result blocked by a full result register is kept
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !ready3) |=> s2_valid)
    else $error("stage-two result lost under stall");

endmodule

>>> dv/row_col_scroll_address_gen_tb.sv
// ----------------------------------------------------------------------------
// row_col_scroll_address_gen_tb: self-checking bench for the scroll address gen
// Loads the row and column scroll tables and requests pixel coordinates under
// several layer settings. Every pixel result is compared with a hand-written
// value or with an in-bench model of the table state and the coordinate math;
// both channels idle at random.
// ----------------------------------------------------------------------------
module row_col_scroll_address_gen_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE       = 6;       // covers the three-stage pipe plus margin
  localparam int PHASE_WORDS  = 72;
  localparam int PHASES       = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // Short names for the command codes in the directed table
  localparam rcs_pkg::cmd_t ROW_WR = rcs_pkg::CMD_ROW_WR;
  localparam rcs_pkg::cmd_t COL_WR = rcs_pkg::CMD_COL_WR;
  localparam rcs_pkg::cmd_t PIX    = rcs_pkg::CMD_PIXEL;
  localparam rcs_pkg::cmd_t NOP    = rcs_pkg::CMD_NOP;

  // Row for the directed table: a word plus an optional hand-written result
  typedef struct {
    rcs_pkg::in_word_t  word;
    bit                 typed;
    rcs_pkg::out_word_t want;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  rcs_pkg::in_word_t  in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  rcs_pkg::out_word_t out_word;
  logic       cfg_we = 1'b0;
  logic [rcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Model of the layer state
  logic [15:0] row_scroll_mem [rcs_pkg::ROW_ENTRIES];
  logic [15:0] col_scroll_mem [rcs_pkg::COL_ENTRIES];
  logic [15:0] scroll_x_reg = '0;
  logic [15:0] scroll_y_reg = '0;
  logic [10:0] delta_x_reg  = '0;
  logic [9:0]  delta_y_reg  = '0;
  logic        flip_reg     = 1'b0;
  logic        wide_reg     = 1'b0;
  logic [9:0]  clip_left_reg = '0;

  rcs_pkg::out_word_t pending_coords [$];
  directed_row_t directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  bit          steady         = 1'b0;   // high: neither side idles
  logic [8:0]  last_row_idx   = '0;

  row_col_scroll_address_gen dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Layer coordinate math: screen pixel -> pixmap (x, y).
  // All sums are modular; only the low bits survive the masks.
  function automatic rcs_pkg::out_word_t predict_source(input rcs_pkg::in_word_t w);
    rcs_pkg::out_word_t r;
    int unsigned wmask, ybase, xbase, rix, cix, sx, sy, dx, dy;
    wmask = wide_reg ? int'(rcs_pkg::MASK_WIDE) : int'(rcs_pkg::MASK_NARROW);
    dx = unsigned'(int'($signed(delta_x_reg)));
    dy = unsigned'(int'($signed(delta_y_reg)));
    ybase = (32'd0 - scroll_y_reg - dy) & 32'h1ff;
    if (flip_reg) ybase = (int'(rcs_pkg::FLIP_Y_ORIGIN) - ybase) & 32'h1ff;
    rix = ((w.screen_row - dy) & 32'h1ff) % rcs_pkg::ROW_ENTRIES;
    xbase = (32'd0 - scroll_x_reg - row_scroll_mem[rix] - dx + clip_left_reg) & wmask;
    if (flip_reg) xbase = (int'(rcs_pkg::FLIP_X_ORIGIN) - xbase) & wmask;
    sx = (xbase + w.screen_col) & wmask;
    cix = ((sx & 32'h3ff) >> rcs_pkg::COL_SHIFT) % rcs_pkg::COL_ENTRIES;
    sy = (ybase + w.screen_row - col_scroll_mem[cix]) & 32'h1ff;
    r.source_x = rcs_pkg::X_W'(sx);
    r.source_y = rcs_pkg::Y_W'(sy);
    return r;
  endfunction

  // Apply an accepted word to the model; queue the result of a pixel request
  task automatic absorb_word(input rcs_pkg::in_word_t w, input bit typed,
                             input rcs_pkg::out_word_t want);
    case (w.command)
      rcs_pkg::CMD_ROW_WR: begin
        if (w.table_index < rcs_pkg::ROW_ENTRIES)
          row_scroll_mem[w.table_index] = w.table_data;
      end
      rcs_pkg::CMD_COL_WR: begin
        if (w.table_index < rcs_pkg::COL_ENTRIES)
          col_scroll_mem[w.table_index] = w.table_data;
      end
      rcs_pkg::CMD_PIXEL: pending_coords.push_back(typed ? want : predict_source(w));
      default: ;
    endcase
  endtask

  // Present one word after a random gap; hold it until the handshake
  task automatic push_word(input rcs_pkg::in_word_t w, input bit typed,
                           input rcs_pkg::out_word_t want);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    absorb_word(w, typed, want);
  endtask

  // Drop valid and let every expected result drain out of the pipe
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_we after the last one
  task automatic cfg_write(input logic [rcs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      rcs_pkg::REG_SCROLL_X:     scroll_x_reg  = data;
      rcs_pkg::REG_SCROLL_Y:     scroll_y_reg  = data;
      rcs_pkg::REG_DELTA_X:      delta_x_reg   = data[10:0];
      rcs_pkg::REG_DELTA_Y:      delta_y_reg   = data[9:0];
      rcs_pkg::REG_FLIP_SCREEN:  flip_reg      = data[0];
      rcs_pkg::REG_DOUBLE_WIDTH: wide_reg      = data[0];
      rcs_pkg::REG_CLIP_LEFT:    clip_left_reg = data[9:0];
      default: ;
    endcase
  endtask

  task automatic program_layer(input logic [15:0] sxw, input logic [15:0] syw,
                               input logic [15:0] dxw, input logic [15:0] dyw,
                               input logic [15:0] flipw, input logic [15:0] widew,
                               input logic [15:0] clipw);
    cfg_write(rcs_pkg::REG_SCROLL_X, sxw);
    cfg_write(rcs_pkg::REG_SCROLL_Y, syw);
    cfg_write(rcs_pkg::REG_DELTA_X, dxw);
    cfg_write(rcs_pkg::REG_DELTA_Y, dyw);
    cfg_write(rcs_pkg::REG_FLIP_SCREEN, flipw);
    cfg_write(rcs_pkg::REG_DOUBLE_WIDTH, widew);
    cfg_write(rcs_pkg::REG_CLIP_LEFT, clipw);
    cfg_we <= 1'b0;
  endtask

  function automatic directed_row_t mk_row(input rcs_pkg::cmd_t c, input logic [8:0] idx,
                                           input logic [15:0] data, input logic [8:0] row,
                                           input logic [9:0] col, input bit typed,
                                           input logic [9:0] wx, input logic [8:0] wy);
    directed_row_t d;
    d.word.command     = c;
    d.word.table_index = idx;
    d.word.table_data  = data;
    d.word.screen_row  = row;
    d.word.screen_col  = col;
    d.typed            = typed;
    d.want.source_x    = wx;
    d.want.source_y    = wy;
    return d;
  endfunction

  // Random word; "live" is low for words the block merely ignores
  task automatic draw_word(output rcs_pkg::in_word_t w, output bit live);
    int unsigned pick;
    w.table_index = 9'($urandom_range(0, 511));
    w.table_data  = 16'($urandom_range(0, 65535));
    w.screen_row  = 9'($urandom_range(0, 511));
    w.screen_col  = 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w.command = rcs_pkg::CMD_PIXEL;
      // aim a third of the requests at the row entry written last
      if ($urandom_range(0, 2) == 0) w.screen_row = 9'(last_row_idx + delta_y_reg);
    end else if (pick < 78) begin
      w.command = rcs_pkg::CMD_ROW_WR;
      last_row_idx = w.table_index;
    end else if (pick < 95) begin
      w.command = rcs_pkg::CMD_COL_WR;
      // mostly in range; the rest may land beyond the column table
      if ($urandom_range(0, 3) != 0)
        w.table_index = 9'($urandom_range(0, rcs_pkg::COL_ENTRIES - 1));
    end else begin
      w.command = rcs_pkg::CMD_NOP;
    end
    live = !(w.command == rcs_pkg::CMD_NOP ||
             (w.command == rcs_pkg::CMD_COL_WR && w.table_index >= rcs_pkg::COL_ENTRIES));
  endtask

  // Result side: check every taken result, then draw the next stall
  always @(posedge clk) begin : result_check
    rcs_pkg::out_word_t want;
    int unsigned n;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_coords.size() == 0) begin
        flag_error($sformatf("result x=%0d y=%0d with nothing pending",
                             out_word.source_x, out_word.source_y));
      end else begin
        want = pending_coords.pop_front();
        if (out_word.source_x !== want.source_x)
          flag_error($sformatf("source_x got %0d want %0d", out_word.source_x, want.source_x));
        if (out_word.source_y !== want.source_y)
          flag_error($sformatf("source_y got %0d want %0d", out_word.source_y, want.source_y));
      end
      n = steady ? 0 : $urandom_range(0, 5);
      out_ready  <= (n == 0);
      stall_left <= n;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    rcs_pkg::in_word_t  w;
    rcs_pkg::out_word_t none;
    bit        live;
    int unsigned counted;

    none = '0;
    foreach (row_scroll_mem[i]) row_scroll_mem[i] = '0;
    foreach (col_scroll_mem[i]) col_scroll_mem[i] = '0;

    // Directed: reset state first, then table edges and write-then-read hazards
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd0,   10'd0,    1, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'h1ff, 16'hffff, 9'd511, 10'd1023, 1, 10'd511, 9'd511));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd5,   10'd600,  1, 10'd88,  9'd5));
    directed_rows.push_back(mk_row(NOP,    9'h1ff, 16'hffff, 9'h1ff, 10'h3ff,  0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(NOP,    9'd0,   16'h0000, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(ROW_WR, 9'd0,   16'hffff, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(ROW_WR, 9'd511, 16'h8000, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(COL_WR, 9'd0,   16'h0001, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(COL_WR, 9'd127, 16'hffff, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    // writes beyond the column table are dropped
    directed_rows.push_back(mk_row(COL_WR, 9'd128, 16'h1234, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(COL_WR, 9'd511, 16'hffff, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd0,   10'd0,    1, 10'd1,   9'd511));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd511, 10'd1016, 1, 10'd504, 9'd511));
    // back-to-back write then read of the same entries
    directed_rows.push_back(mk_row(ROW_WR, 9'd3,   16'h0010, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd3,   10'd7,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(COL_WR, 9'd62,  16'h0005, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd3,   10'd7,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(ROW_WR, 9'd3,   16'h0000, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd3,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'h1ff, 16'hffff, 9'd256, 10'd512,  0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(COL_WR, 9'd0,   16'h0000, 9'd0,   10'd0,    0, 10'd0,   9'd0));
    directed_rows.push_back(mk_row(PIX,    9'd0,   16'h0000, 9'd0,   10'd0,    0, 10'd0,   9'd0));

    // Hold reset, then release; the clearing pass shows as in_ready low
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own layer setting
    for (int p = 0; p < PHASES; p++) begin
      drain_pipe();
      case (p)
        0: program_layer(16'h0000, 16'h0000, 16'h0400, 16'h0200, 16'h0000, 16'h0001, 16'h0000);
        1: program_layer(16'hffff, 16'hffff, 16'h03ff, 16'h01ff, 16'h0001, 16'h0001, 16'h03ff);
        2: program_layer(16'hffff, 16'h0000, 16'h0400, 16'h01ff, 16'h0001, 16'h0000, 16'h03ff);
        default: program_layer(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
      endcase
      counted = 0;
      while (counted < PHASE_WORDS) begin
        // switch between idling and full-rate stretches now and then
        if ($urandom_range(0, 29) == 0) steady = ($urandom_range(0, 2) == 0);
        draw_word(w, live);
        push_word(w, 1'b0, none);
        if (live) counted++;
      end
    end

    drain_pipe();
    if (mismatch_count == 0 && pending_coords.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (pending_coords.size() != 0)
        flag_error($sformatf("%0d results never arrived", pending_coords.size()));
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
